>>> src/cpu8x_pkg.sv
// ----------------------------------------------------------------------------
// cpu8x_pkg
// Shared types and constants of the 8-bit execute unit: operation codes,
// flag positions, reset values and the structs passed to the ALU.
// ----------------------------------------------------------------------------
package cpu8x_pkg;

   // The stack store depth is a power of two; the index is the low sp bits.
   localparam int STACK_DEPTH = 256;
   localparam int STK_AW      = $clog2(STACK_DEPTH);

   localparam int REQ_W = 32;
   localparam int RSP_W = 80;

   // Flag bit positions: N V - B D I Z C.
   localparam int FL_C = 0;
   localparam int FL_Z = 1;
   localparam int FL_I = 2;
   localparam int FL_D = 3;
   localparam int FL_B = 4;
   localparam int FL_U = 5;
   localparam int FL_V = 6;
   localparam int FL_N = 7;

   localparam logic [7:0] SP_RESET    = 8'hFD;
   localparam logic [7:0] FLAGS_RESET = 8'h24;
   localparam logic [7:0] PUSH_FLAGS  = 8'h30;

   typedef enum logic [5:0] {
      OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BIT = 6'd3,
      OP_BRK = 6'd4,  OP_CLC = 6'd5,  OP_CLD = 6'd6,  OP_CLI = 6'd7,
      OP_CLV = 6'd8,  OP_CMP = 6'd9,  OP_CPX = 6'd10, OP_CPY = 6'd11,
      OP_DEC = 6'd12, OP_DEX = 6'd13, OP_DEY = 6'd14, OP_EOR = 6'd15,
      OP_INC = 6'd16, OP_INX = 6'd17, OP_INY = 6'd18, OP_LDA = 6'd19,
      OP_LDX = 6'd20, OP_LDY = 6'd21, OP_LSR = 6'd22, OP_NOP = 6'd23,
      OP_ORA = 6'd24, OP_PHA = 6'd25, OP_PHP = 6'd26, OP_PLA = 6'd27,
      OP_PLP = 6'd28, OP_ROL = 6'd29, OP_ROR = 6'd30, OP_RTI = 6'd31,
      OP_SBC = 6'd32, OP_SEC = 6'd33, OP_SED = 6'd34, OP_SEI = 6'd35,
      OP_STA = 6'd36, OP_STX = 6'd37, OP_STY = 6'd38, OP_TAX = 6'd39,
      OP_TAY = 6'd40, OP_TSX = 6'd41, OP_TXA = 6'd42, OP_TXS = 6'd43,
      OP_TYA = 6'd44
   } op_type;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] sp;
      logic [7:0] flags;
   } regs_type;

   typedef struct packed {
      logic [7:0]  result_value;
      logic        mem_write;
      logic [15:0] mem_address;
      logic [7:0]  mem_data;
      logic        irq_request;
   } side_type;

   typedef struct packed {
      logic       push;
      logic [7:0] data;
   } stack_wr_type;

endpackage

>>> src/cpu8_alu_register_execute.sv
// A request word is registered into the execute stage as it is taken; its result
// word is registered into the output stage when that stage is empty or being read.
// Throughput: one word per cycle while results are taken; the stack RAM read is
// issued as a word is taken and its data is used by the execute stage with that word.
// Reset clears A, X, Y, sets SP to 0xFD and the flags to 0x24, and clears the
// per-entry valid bits of the stack store at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// cpu8_alu_register_execute
// Execute unit of an 8-bit CPU with register file and stack store.
// ----------------------------------------------------------------------------
module cpu8_alu_register_execute (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // Fields from bit 0: op[5:0], operand[13:6], store_address[29:14], zero pad.
   input  logic [cpu8x_pkg::REQ_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // Fields from bit 0: result_value[7:0], mem_write[8], mem_address[24:9],
   // mem_data[32:25], irq_request[33], accumulator[41:34], index_x[49:42],
   // index_y[57:50], stack_pointer[65:58], status[73:66], zero pad.
   output logic [cpu8x_pkg::RSP_W-1:0]   rsp_tdata
);
   import cpu8x_pkg::*;

   regs_type     regs_ff;
   regs_type     regs_next;
   side_type     side;
   stack_wr_type stk;

   logic              e_valid_ff;
   logic [5:0]        e_op_ff;
   logic [7:0]        e_operand_ff;
   logic [15:0]       e_addr_ff;

   logic              fwd_hit_ff;
   logic [7:0]        fwd_data_ff;
   logic              entry_valid_ff;
   logic [STACK_DEPTH-1:0] valid_ff;

   logic              rsp_valid_ff;
   logic [RSP_W-1:0]  rsp_data_ff;

   logic              accept;
   logic              e_fire;
   logic [7:0]        cur_sp;
   logic [7:0]        rd_sp;
   logic [STK_AW-1:0] rd_idx;
   logic [STK_AW-1:0] wr_idx;
   logic              wr_en;
   logic [7:0]        ram_rd_data;
   logic [7:0]        pull_data;

   assign e_fire     = e_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !e_valid_ff || e_fire;
   assign accept     = req_tvalid && req_tready;

   // A pull reads one above the stack pointer left by the word now executing.
   assign cur_sp = e_fire ? regs_next.sp : regs_ff.sp;
   assign rd_sp  = cur_sp + 8'd1;
   assign rd_idx = rd_sp[STK_AW-1:0];
   assign wr_idx = regs_ff.sp[STK_AW-1:0];
   assign wr_en  = e_fire && stk.push;

   cpu8x_ram #(
      .WIDTH(8),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (stk.data),
      .rd_en   (accept),
      .rd_addr (rd_idx),
      .rd_data (ram_rd_data)
   );

   // A push in the same cycle as the read wins over the RAM's old contents;
   // an entry never written reads as zero.
   always_comb begin
      if (fwd_hit_ff) begin
         pull_data = fwd_data_ff;
      end else if (entry_valid_ff) begin
         pull_data = ram_rd_data;
      end else begin
         pull_data = 8'd0;
      end
   end

   cpu8x_alu u_alu (
      .op            (e_op_ff),
      .operand       (e_operand_ff),
      .store_address (e_addr_ff),
      .regs          (regs_ff),
      .pull_data     (pull_data),
      .regs_next     (regs_next),
      .side          (side),
      .stk           (stk)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.acc   <= 8'd0;
         regs_ff.x     <= 8'd0;
         regs_ff.y     <= 8'd0;
         regs_ff.sp    <= SP_RESET;
         regs_ff.flags <= FLAGS_RESET;
         e_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         valid_ff      <= '0;
         fwd_hit_ff    <= 1'b0;
      end else begin
         if (e_fire) begin
            regs_ff <= regs_next;
         end
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (accept) begin
            e_valid_ff <= 1'b1;
            fwd_hit_ff <= wr_en && (wr_idx == rd_idx);
         end else if (e_fire) begin
            e_valid_ff <= 1'b0;
         end
         if (e_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         e_op_ff        <= req_tdata[5:0];
         e_operand_ff   <= req_tdata[13:6];
         e_addr_ff      <= req_tdata[29:14];
         fwd_data_ff    <= stk.data;
         entry_valid_ff <= valid_ff[rd_idx];
      end
      if (e_fire) begin
         rsp_data_ff <= {6'd0, regs_next.flags, regs_next.sp, regs_next.y, regs_next.x,
                         regs_next.acc, side.irq_request, side.mem_data,
                         side.mem_address, side.mem_write, side.result_value};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> src/cpu8x_ram.sv
// ----------------------------------------------------------------------------
// cpu8x_ram
// Generic single-write, single-read synchronous RAM. The read data register
// loads only when a read is enabled and returns the old contents on a
// same-address write.
// ----------------------------------------------------------------------------
module cpu8x_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/cpu8x_alu.sv
// ----------------------------------------------------------------------------
// cpu8x_alu
// Execute logic for one operation: computes the next register file, the
// side results (returned value, store, interrupt request) and a stack push.
// ----------------------------------------------------------------------------
module cpu8x_alu (
   input  logic [5:0]              op,
   input  logic [7:0]              operand,
   input  logic [15:0]             store_address,
   input  cpu8x_pkg::regs_type     regs,
   input  logic [7:0]              pull_data,
   output cpu8x_pkg::regs_type     regs_next,
   output cpu8x_pkg::side_type     side,
   output cpu8x_pkg::stack_wr_type stk
);
   import cpu8x_pkg::*;

   function automatic logic [7:0] with_nz(input logic [7:0] f, input logic [7:0] v);
      logic [7:0] t;
      t       = f;
      t[FL_Z] = (v == 8'd0);
      t[FL_N] = v[7];
      return t;
   endfunction

   logic [8:0] adc_sum;
   logic [8:0] sbc_sum;
   logic [8:0] cmp_a;
   logic [8:0] cmp_x;
   logic [8:0] cmp_y;
   logic [7:0] val;
   logic       cin;

   assign cin     = regs.flags[FL_C];
   // Subtraction is an add of the inverted operand; carry out means no borrow.
   assign adc_sum = {1'b0, regs.acc} + {1'b0, operand} + {8'd0, cin};
   assign sbc_sum = {1'b0, regs.acc} + {1'b0, ~operand} + {8'd0, cin};
   assign cmp_a   = {1'b0, regs.acc} + {1'b0, ~operand} + 9'd1;
   assign cmp_x   = {1'b0, regs.x} + {1'b0, ~operand} + 9'd1;
   assign cmp_y   = {1'b0, regs.y} + {1'b0, ~operand} + 9'd1;

   always_comb begin
      regs_next = regs;
      side      = '0;
      stk       = '0;
      val       = 8'd0;
      case (op)
         OP_ADC: begin
            regs_next.acc          = adc_sum[7:0];
            regs_next.flags        = with_nz(regs.flags, adc_sum[7:0]);
            regs_next.flags[FL_C]  = adc_sum[8];
            regs_next.flags[FL_V]  = ~(regs.acc[7] ^ operand[7]) & (regs.acc[7] ^ adc_sum[7]);
         end
         OP_SBC: begin
            regs_next.acc          = sbc_sum[7:0];
            regs_next.flags        = with_nz(regs.flags, sbc_sum[7:0]);
            regs_next.flags[FL_C]  = sbc_sum[8];
            regs_next.flags[FL_V]  = (regs.acc[7] ^ operand[7]) & (regs.acc[7] ^ sbc_sum[7]);
         end
         OP_AND: begin
            regs_next.acc   = regs.acc & operand;
            regs_next.flags = with_nz(regs.flags, regs.acc & operand);
         end
         OP_EOR: begin
            regs_next.acc   = regs.acc ^ operand;
            regs_next.flags = with_nz(regs.flags, regs.acc ^ operand);
         end
         OP_ORA: begin
            regs_next.acc   = regs.acc | operand;
            regs_next.flags = with_nz(regs.flags, regs.acc | operand);
         end
         OP_ASL, OP_LSR, OP_ROL, OP_ROR, OP_INC, OP_DEC: begin
            case (op)
               OP_ASL:  val = {operand[6:0], 1'b0};
               OP_LSR:  val = {1'b0, operand[7:1]};
               OP_ROL:  val = {operand[6:0], cin};
               OP_ROR:  val = {cin, operand[7:1]};
               OP_INC:  val = operand + 8'd1;
               default: val = operand - 8'd1;
            endcase
            regs_next.flags = with_nz(regs.flags, val);
            if (op == OP_ASL || op == OP_ROL) begin
               regs_next.flags[FL_C] = operand[7];
            end else if (op == OP_LSR || op == OP_ROR) begin
               regs_next.flags[FL_C] = operand[0];
            end
            side.result_value = val;
         end
         OP_BIT: begin
            regs_next.flags[FL_V] = operand[6];
            regs_next.flags[FL_Z] = ((operand & regs.acc) == 8'd0);
            regs_next.flags[FL_N] = operand[7];
         end
         OP_BRK: side.irq_request = ~regs.flags[FL_I];
         OP_CLC: regs_next.flags[FL_C] = 1'b0;
         OP_CLD: regs_next.flags[FL_D] = 1'b0;
         OP_CLI: regs_next.flags[FL_I] = 1'b0;
         OP_CLV: regs_next.flags[FL_V] = 1'b0;
         OP_SEC: regs_next.flags[FL_C] = 1'b1;
         OP_SED: regs_next.flags[FL_D] = 1'b1;
         OP_SEI: regs_next.flags[FL_I] = 1'b1;
         OP_CMP: begin
            regs_next.flags       = with_nz(regs.flags, cmp_a[7:0]);
            regs_next.flags[FL_C] = cmp_a[8];
         end
         OP_CPX: begin
            regs_next.flags       = with_nz(regs.flags, cmp_x[7:0]);
            regs_next.flags[FL_C] = cmp_x[8];
         end
         OP_CPY: begin
            regs_next.flags       = with_nz(regs.flags, cmp_y[7:0]);
            regs_next.flags[FL_C] = cmp_y[8];
         end
         OP_DEX: begin
            regs_next.x     = regs.x - 8'd1;
            regs_next.flags = with_nz(regs.flags, regs.x - 8'd1);
         end
         OP_DEY: begin
            regs_next.y     = regs.y - 8'd1;
            regs_next.flags = with_nz(regs.flags, regs.y - 8'd1);
         end
         OP_INX: begin
            regs_next.x     = regs.x + 8'd1;
            regs_next.flags = with_nz(regs.flags, regs.x + 8'd1);
         end
         OP_INY: begin
            regs_next.y     = regs.y + 8'd1;
            regs_next.flags = with_nz(regs.flags, regs.y + 8'd1);
         end
         OP_LDA: begin
            regs_next.acc   = operand;
            regs_next.flags = with_nz(regs.flags, operand);
         end
         OP_LDX: begin
            regs_next.x     = operand;
            regs_next.flags = with_nz(regs.flags, operand);
         end
         OP_LDY: begin
            regs_next.y     = operand;
            regs_next.flags = with_nz(regs.flags, operand);
         end
         OP_PHA: begin
            stk.push     = 1'b1;
            stk.data     = regs.acc;
            regs_next.sp = regs.sp - 8'd1;
         end
         OP_PHP: begin
            stk.push     = 1'b1;
            stk.data     = regs.flags | PUSH_FLAGS;
            regs_next.sp = regs.sp - 8'd1;
         end
         OP_PLA: begin
            regs_next.sp    = regs.sp + 8'd1;
            regs_next.acc   = pull_data;
            regs_next.flags = with_nz(regs.flags, pull_data);
         end
         OP_PLP, OP_RTI: begin
            regs_next.sp              = regs.sp + 8'd1;
            regs_next.flags           = pull_data;
            regs_next.flags[FL_B]     = 1'b0;
            regs_next.flags[FL_U]     = 1'b1;
         end
         OP_STA, OP_STX, OP_STY: begin
            side.mem_write   = 1'b1;
            side.mem_address = store_address;
            case (op)
               OP_STA:  side.mem_data = regs.acc;
               OP_STX:  side.mem_data = regs.x;
               default: side.mem_data = regs.y;
            endcase
         end
         OP_TAX: begin
            regs_next.x     = regs.acc;
            regs_next.flags = with_nz(regs.flags, regs.acc);
         end
         OP_TAY: begin
            regs_next.y     = regs.acc;
            regs_next.flags = with_nz(regs.flags, regs.acc);
         end
         OP_TSX: begin
            regs_next.x     = regs.sp;
            regs_next.flags = with_nz(regs.flags, regs.sp);
         end
         OP_TXA: begin
            regs_next.acc   = regs.x;
            regs_next.flags = with_nz(regs.flags, regs.x);
         end
         OP_TXS: regs_next.sp = regs.x;
         OP_TYA: begin
            regs_next.acc   = regs.y;
            regs_next.flags = with_nz(regs.flags, regs.y);
         end
         default: begin
            regs_next = regs;
         end
      endcase
   end

endmodule

>>> src/cpu8x_checker.sv
// ----------------------------------------------------------------------------
// cpu8x_checker
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module cpu8x_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [cpu8x_pkg::RSP_W-1:0] rsp_tdata
);
   import cpu8x_pkg::*;

   localparam int RV_LO      = 0;
   localparam int MW_BIT     = 8;
   localparam int IRQ_BIT    = 33;
   localparam int STATUS_LO  = 66;

   // Nothing is presented right after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   // A rising result valid must match a request word taken earlier.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 2))
      else $error("result without a matching request");

   // A stalled result word holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // The unused status bit always reads as one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[STATUS_LO + FL_U])
      else $error("status bit 5 clear");

   // A store returns no value and raises no interrupt.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[MW_BIT] |->
         rsp_tdata[RV_LO +: 8] == 8'd0 && !rsp_tdata[IRQ_BIT])
      else $error("store carries other side results");

endmodule

bind cpu8_alu_register_execute cpu8x_checker u_cpu8x_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
